@@ rtl/tts_pkg.sv @@
// Shared types and constants of the tick task scheduler.
// Used by tts_slot_mem, tts_cmp_unit and tick_task_scheduler_unit; depends on nothing.
`default_nettype none

package tts_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int TICK_W         = 32;
  localparam int ORDER_W        = 32;
  localparam int HANDLE_W       = 16;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_FIRED    = 2'd2,
    KIND_DONE     = 2'd3
  } kind_t;

  localparam logic ACTION_TICK     = 1'b0;
  localparam logic ACTION_SCHEDULE = 1'b1;

  // One stored task.
  typedef struct packed {
    logic [TICK_W-1:0]   due;
    logic [ORDER_W-1:0]  order;
    logic [HANDLE_W-1:0] handle;
    logic                cleanup;
  } slot_entry_t;

  // Best candidate found so far in a scan.
  typedef struct packed {
    logic                have;
    logic [TICK_W-1:0]   due;
    logic [ORDER_W-1:0]  age;
  } best_t;

endpackage

`default_nettype wire

@@ rtl/tts_slot_mem.sv @@
// Task slot memory: one write port and one registered read port.
// Depends on tts_pkg for the slot entry type.
`default_nettype none

module tts_slot_mem #(
  parameter int SLOTS = tts_pkg::TASK_SLOTS_DEF,
  parameter int IDX_W = 4
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [IDX_W-1:0]      wr_addr,
  input  wire tts_pkg::slot_entry_t  wr_data,
  input  wire logic [IDX_W-1:0]      rd_addr,
  output tts_pkg::slot_entry_t       rd_data
);

  tts_pkg::slot_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/tts_cmp_unit.sv @@
// Shared compare unit: decides whether a slot beats the best due task so far.
// Depends on tts_pkg for the entry and candidate types.
`default_nettype none

module tts_cmp_unit (
  input  wire tts_pkg::slot_entry_t            entry,
  input  wire logic                            entry_valid,
  input  wire logic [tts_pkg::TICK_W-1:0]      tick,
  input  wire logic [tts_pkg::ORDER_W-1:0]     arrival,
  input  wire tts_pkg::best_t                  best,
  output logic                                 take,
  output logic [tts_pkg::ORDER_W-1:0]          cand_age
);

  logic is_due;
  logic beats;

  // Age is taken modulo 2^32 so that ordering survives a wrap of the arrival count.
  assign cand_age = arrival - entry.order;
  assign is_due   = entry_valid && (entry.due <= tick);
  assign beats    = !best.have || (entry.due < best.due) ||
                    ((entry.due == best.due) && (cand_age > best.age));
  assign take     = is_due && beats;

endmodule

`default_nettype wire

@@ rtl/tick_task_scheduler_unit.sv @@
// Top level of the tick task scheduler: sequencer, tick and arrival counters, slot valid bits.
// Depends on tts_pkg, tts_slot_mem and tts_cmp_unit.
`default_nettype none

// Channel   Handshake               Payload
// request   req_valid / req_stall   action, due_at, task_handle, wants_cleanup
// result    rsp_valid / rsp_stall   kind, fired_handle, fired_cleanup, current_tick, last
//
// A schedule request is accepted and stored in the idle state and answered from the
// response state. A tick request makes one full pass of the shared compare unit over the
// slot memory for every task that fires and a final pass that finds none; each pass
// reads one slot per cycle through the memory's single read port.
// Reset clears the tick and arrival counters and all slot valid bits; slot contents
// are only used while valid and need no clearing. A stall on the result channel
// holds the sequencer in its emit state; no request is taken until the previous one
// has handed its last result to the output register.

module tick_task_scheduler_unit #(
  parameter int TASK_SLOTS = tts_pkg::TASK_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // request channel
  input  wire logic                            req_valid,
  output logic                                 req_stall,
  input  wire logic                            action,
  input  wire logic [tts_pkg::TICK_W-1:0]      due_at,
  input  wire logic [tts_pkg::HANDLE_W-1:0]    task_handle,
  input  wire logic                            wants_cleanup,
  // result channel
  output logic                                 rsp_valid,
  input  wire logic                            rsp_stall,
  output logic [1:0]                           kind,
  output logic [tts_pkg::HANDLE_W-1:0]         fired_handle,
  output logic                                 fired_cleanup,
  output logic [tts_pkg::TICK_W-1:0]           current_tick,
  output logic                                 last
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_SCAN,
    S_LAST,
    S_FIRE
  } state_t;

  state_t state;

  logic [tts_pkg::TICK_W-1:0]   tick_count;
  logic [tts_pkg::ORDER_W-1:0]  arrival_counter;
  logic [TASK_SLOTS-1:0]        slot_valid;

  // Scan position and the compare stage that follows it in the next cycle.
  logic [IDX_W-1:0]             scan_idx;
  logic                         cmp_pend;
  logic [IDX_W-1:0]             cmp_idx;

  tts_pkg::best_t               best;
  logic [IDX_W-1:0]             best_idx;
  logic [tts_pkg::HANDLE_W-1:0] best_handle;
  logic                         best_cleanup;

  tts_pkg::kind_t               resp_kind;

  logic                         free_found;
  logic [IDX_W-1:0]             free_idx;
  logic                         req_take;
  logic                         rsp_free;
  logic                         emit;
  logic                         do_store;
  tts_pkg::slot_entry_t         wr_entry;
  tts_pkg::slot_entry_t         rd_entry;
  logic                         take;
  logic [tts_pkg::ORDER_W-1:0]  cand_age;

  // Lowest free slot, matching the fill order of the table.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign req_stall = (state != S_IDLE);
  assign req_take  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  // A new result is loaded into the output register in this cycle.
  assign emit      = rsp_free && ((state == S_RESP) || (state == S_FIRE));

  // A schedule request is stored unless it is already late or the table is full.
  assign do_store = req_take && (action == tts_pkg::ACTION_SCHEDULE) &&
                    !(due_at < tick_count) && free_found;

  assign wr_entry.due     = due_at;
  assign wr_entry.order   = arrival_counter;
  assign wr_entry.handle  = task_handle;
  assign wr_entry.cleanup = wants_cleanup;

  tts_slot_mem #(
    .SLOTS (TASK_SLOTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (do_store),
    .wr_addr (free_idx),
    .wr_data (wr_entry),
    .rd_addr (scan_idx),
    .rd_data (rd_entry)
  );

  tts_cmp_unit u_cmp (
    .entry       (rd_entry),
    .entry_valid (slot_valid[cmp_idx]),
    .tick        (tick_count),
    .arrival     (arrival_counter),
    .best        (best),
    .take        (take),
    .cand_age    (cand_age)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      tick_count      <= '0;
      arrival_counter <= '0;
      slot_valid      <= '0;
      scan_idx        <= '0;
      cmp_pend        <= 1'b0;
      best.have       <= 1'b0;
      rsp_valid       <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && !emit) begin
        rsp_valid <= 1'b0;
      end

      // The compare stage sees the entry read in the previous cycle.
      cmp_pend <= (state == S_SCAN);
      cmp_idx  <= scan_idx;
      if (cmp_pend && take) begin
        best.have    <= 1'b1;
        best.due     <= rd_entry.due;
        best.age     <= cand_age;
        best_idx     <= cmp_idx;
        best_handle  <= rd_entry.handle;
        best_cleanup <= rd_entry.cleanup;
      end

      case (state)
        S_IDLE: begin
          if (req_take) begin
            if (action == tts_pkg::ACTION_SCHEDULE) begin
              if (do_store) begin
                slot_valid[free_idx] <= 1'b1;
                arrival_counter      <= arrival_counter + 1'b1;
                resp_kind            <= tts_pkg::KIND_ACCEPTED;
              end else begin
                resp_kind <= tts_pkg::KIND_REJECTED;
              end
              state <= S_RESP;
            end else begin
              if (tick_count != tts_pkg::TICK_MAX) begin
                tick_count <= tick_count + 1'b1;
              end
              scan_idx  <= '0;
              best.have <= 1'b0;
              state     <= S_SCAN;
            end
          end
        end

        S_RESP: begin
          if (rsp_free) begin
            rsp_valid     <= 1'b1;
            kind          <= resp_kind;
            fired_handle  <= '0;
            fired_cleanup <= 1'b0;
            current_tick  <= tick_count;
            last          <= 1'b1;
            state         <= S_IDLE;
          end
        end

        S_SCAN: begin
          if (scan_idx == LAST_IDX) begin
            state <= S_LAST;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end

        S_LAST: begin
          // The final slot is compared in this cycle.
          state <= S_FIRE;
        end

        S_FIRE: begin
          if (rsp_free) begin
            rsp_valid    <= 1'b1;
            current_tick <= tick_count;
            if (best.have) begin
              kind                 <= tts_pkg::KIND_FIRED;
              fired_handle         <= best_handle;
              fired_cleanup        <= best_cleanup;
              last                 <= 1'b0;
              slot_valid[best_idx] <= 1'b0;
              scan_idx             <= '0;
              best.have            <= 1'b0;
              state                <= S_SCAN;
            end else begin
              kind          <= tts_pkg::KIND_DONE;
              fired_handle  <= '0;
              fired_cleanup <= 1'b0;
              last          <= 1'b1;
              state         <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
